@@ design/lrmt_pkg.sv @@
// shared types, constants and helpers of the lazy range-add / range-min tree
`timescale 1ns / 1ps
`default_nettype none
package lrmt_pkg;

    localparam int LEAVES_DEF = 1024;
    localparam int DATA_W     = 32;
    localparam int RANGE_W    = 11;
    localparam int ADDR_W     = 3;

    // command codes
    localparam logic CMD_ADD = 1'b0;
    localparam logic CMD_MIN = 1'b1;

    // register index, taken from paddr[2]
    localparam logic REG_FILL = 1'b0;
    localparam logic REG_CAP  = 1'b1;

    // walk frame phases
    localparam logic [1:0] PH_ENTER = 2'd0;
    localparam logic [1:0] PH_LEFT  = 2'd1;
    localparam logic [1:0] PH_RIGHT = 2'd2;

    typedef enum logic [2:0] {
        ST_CLR,
        ST_IDLE,
        ST_VISIT,
        ST_TOUCH,
        ST_C1,
        ST_C2,
        ST_POST,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [DATA_W-1:0] fill;
        logic [DATA_W-1:0] cap;
        logic              refill;
    } cfg_t;

    function automatic logic [DATA_W-1:0] smin(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b);
        return ($signed(b) < $signed(a)) ? b : a;
    endfunction

endpackage
`default_nettype wire

@@ design/lrmt_apb.sv @@
// apb register file: fill value and cap value
`timescale 1ns / 1ps
`default_nettype none
module lrmt_apb
    import lrmt_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    output cfg_t                   cfg
);

    logic [DATA_W-1:0] fill_reg;
    logic [DATA_W-1:0] cap_reg;
    logic              wr;

    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            cap_reg  <= 32'h7FFF_FFFF;
        end
        else if (wr)
        begin
            if (paddr[2] == REG_FILL)
            begin
                fill_reg <= pwdata;
            end
            else
            begin
                cap_reg <= pwdata;
            end
        end
    end

    // read back
    assign prdata = (paddr[2] == REG_CAP) ? cap_reg : fill_reg;

    assign cfg.fill   = fill_reg;
    assign cfg.cap    = cap_reg;
    assign cfg.refill = wr && (paddr[2] == REG_FILL);

endmodule
`default_nettype wire

@@ design/lazy_range_add_min_tree_core.sv @@
// lazy segment tree over LEAVES elements: range add and range minimum
//
// input channel (in_valid / in_stall): one request per command, range add
// (command 0) or range minimum (command 1) over [range_start, range_end).
// output channel (out_valid / out_stall): one min_value per minimum request,
// none for an add. The result sits in an output register; a new request is
// taken while it waits, but the next result waits until it is taken.
// a request walks the tree from the root with an explicit frame stack; the
// node state lies in one synchronous memory of 2*P-1 entries {minimum, pending}.
// each touched node is read, then its pending add is folded and written back;
// at an inner node both children's pending adds are then read, modified and
// written. One request is at work at a time.
// after reset, and after each fill_value write, a clearing pass writes every
// node with fill_value and zero pending, with in_stall high.
// configuration is an apb port; pready is always high.
`timescale 1ns / 1ps
`default_nettype none
module lazy_range_add_min_tree_core
    import lrmt_pkg::*;
#(
    parameter int LEAVES = LEAVES_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [ADDR_W-1:0]  paddr,
    input  wire logic [DATA_W-1:0]  pwdata,
    output logic      [DATA_W-1:0]  prdata,
    output logic                    pready,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic               command,
    input  wire logic [RANGE_W-1:0] range_start,
    input  wire logic [RANGE_W-1:0] range_end,
    input  wire logic [DATA_W-1:0]  add_value,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic      [DATA_W-1:0]  min_value
);

    localparam int LOG   = $clog2(LEAVES);
    localparam int P     = 1 << LOG;
    localparam int NODES = 2 * P - 1;
    localparam int KW    = LOG + 1;
    localparam int LW    = LOG + 1;
    localparam int D     = LOG + 1;
    localparam int SPW   = (D > 1) ? $clog2(D) : 1;
    localparam int CW    = (LW > RANGE_W) ? LW : RANGE_W;

    cfg_t cfg;

    lrmt_apb u_apb (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    state_t state_reg, state_next;
    logic [SPW-1:0]    sp_reg, sp_next;
    logic [DATA_W-1:0] ret_reg, ret_next;
    logic [DATA_W-1:0] p_reg, p_next;
    logic [KW-1:0]     clr_reg, clr_next;
    logic              cmd_reg;
    logic [CW-1:0]     a_reg, b_reg;
    logic [DATA_W-1:0] v_reg;
    logic              out_valid_reg;
    logic [DATA_W-1:0] out_data_reg;

    // node memory {minimum, pending}
    logic [2*DATA_W-1:0] mem [NODES];
    logic [2*DATA_W-1:0] mem_rd_reg;
    logic                mem_we;
    logic [KW-1:0]       mem_waddr, mem_raddr;
    logic [2*DATA_W-1:0] mem_wdata;

    // frame stack
    logic [KW-1:0] stk_k  [D];
    logic [LW-1:0] stk_l  [D];
    logic [LW-1:0] stk_r  [D];
    logic [1:0]    stk_ph [D];
    logic [DATA_W-1:0] stk_lo [D];

    logic              push, ph_we, lo_we, load_req, out_load;
    logic [SPW-1:0]    push_idx;
    logic [KW-1:0]     push_k;
    logic [LW-1:0]     push_l, push_r;
    logic [1:0]        ph_val;

    // top frame and its classification
    logic [KW-1:0]     tk;
    logic [LW-1:0]     tl, tr, tm;
    logic [1:0]        tph;
    logic [DATA_W-1:0] tlo;
    logic [CW-1:0]     tl_x, tr_x;
    logic [LW:0]       lr_sum;
    logic [KW:0]       c1_w, c2_w;
    logic [KW-1:0]     c1, c2;
    logic              outside, covered, partial, internal;
    logic [DATA_W-1:0] rd_min, rd_pend, pnew, nmin, best;

    assign tk     = stk_k[sp_reg];
    assign tl     = stk_l[sp_reg];
    assign tr     = stk_r[sp_reg];
    assign tph    = stk_ph[sp_reg];
    assign tlo    = stk_lo[sp_reg];
    assign tl_x   = CW'(tl);
    assign tr_x   = CW'(tr);
    assign lr_sum = {1'b0, tl} + {1'b0, tr};
    assign tm     = lr_sum[LW:1];
    assign c1_w   = {tk, 1'b0} + (KW+1)'(1);
    assign c2_w   = {tk, 1'b0} + (KW+1)'(2);
    assign c1     = c1_w[KW-1:0];
    assign c2     = c2_w[KW-1:0];

    assign outside  = (tr_x <= a_reg) || (b_reg <= tl_x);
    assign covered  = (a_reg <= tl_x) && (tr_x <= b_reg);
    assign partial  = !outside && !covered;
    assign internal = (tk < KW'(P - 1));

    assign rd_min  = mem_rd_reg[2*DATA_W-1:DATA_W];
    assign rd_pend = mem_rd_reg[DATA_W-1:0];
    assign pnew    = rd_pend + (covered ? v_reg : '0);
    assign nmin    = smin(rd_min + pnew, cfg.cap);
    assign best    = smin(tlo, ret_reg);

    assign in_stall  = (state_reg != ST_IDLE) || cfg.refill;
    assign out_valid = out_valid_reg;
    assign min_value = out_data_reg;

    // state register and walk registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLR;
            sp_reg    <= '0;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            sp_reg    <= sp_next;
            clr_reg   <= clr_next;
        end
    end

    // request capture and walk payload
    always_ff @(posedge clk)
    begin
        ret_reg <= ret_next;
        p_reg   <= p_next;
        if (load_req)
        begin
            cmd_reg <= command;
            a_reg   <= CW'(range_start);
            b_reg   <= CW'(range_end);
            v_reg   <= (command == CMD_MIN) ? '0 : add_value;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= ret_reg;
        end
    end

    // node memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_rd_reg <= mem[mem_raddr];
    end

    // frame stack writes
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            stk_k[push_idx]  <= push_k;
            stk_l[push_idx]  <= push_l;
            stk_r[push_idx]  <= push_r;
            stk_ph[push_idx] <= PH_ENTER;
        end
        if (ph_we)
        begin
            stk_ph[sp_reg] <= ph_val;
        end
        if (lo_we)
        begin
            stk_lo[sp_reg] <= ret_reg;
        end
    end

    // walk sequencer
    always_comb
    begin
        state_next = state_reg;
        sp_next    = sp_reg;
        ret_next   = ret_reg;
        p_next     = p_reg;
        clr_next   = clr_reg;
        mem_we     = 1'b0;
        mem_waddr  = tk;
        mem_wdata  = '0;
        mem_raddr  = tk;
        push       = 1'b0;
        push_idx   = sp_reg + SPW'(1);
        push_k     = c1;
        push_l     = tl;
        push_r     = tm;
        ph_we      = 1'b0;
        ph_val     = PH_LEFT;
        lo_we      = 1'b0;
        load_req   = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            ST_CLR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = {cfg.fill, {DATA_W{1'b0}}};
                if (clr_reg == KW'(NODES - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + KW'(1);
                end
            end
            ST_IDLE:
            begin
                if (in_valid && !in_stall)
                begin
                    load_req   = 1'b1;
                    push       = 1'b1;
                    push_idx   = '0;
                    push_k     = '0;
                    push_l     = '0;
                    push_r     = LW'(P);
                    sp_next    = '0;
                    state_next = ST_VISIT;
                end
            end
            ST_VISIT:
            begin
                case (tph)
                    PH_ENTER:
                    begin
                        if (outside && (cmd_reg == CMD_MIN))
                        begin
                            ret_next = cfg.cap;
                            if (sp_reg == '0)
                            begin
                                state_next = ST_DONE;
                            end
                            else
                            begin
                                sp_next = sp_reg - SPW'(1);
                            end
                        end
                        else
                        begin
                            state_next = ST_TOUCH;
                        end
                    end
                    PH_LEFT:
                    begin
                        lo_we   = 1'b1;
                        push    = 1'b1;
                        push_k  = c2;
                        push_l  = tm;
                        push_r  = tr;
                        ph_we   = 1'b1;
                        ph_val  = PH_RIGHT;
                        sp_next = sp_reg + SPW'(1);
                    end
                    PH_RIGHT:
                    begin
                        if (cmd_reg == CMD_ADD)
                        begin
                            mem_we    = 1'b1;
                            mem_wdata = {best, {DATA_W{1'b0}}};
                        end
                        ret_next = best;
                        if (sp_reg == '0)
                        begin
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            sp_next = sp_reg - SPW'(1);
                        end
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_TOUCH:
            begin
                // fold pending add, clamp, write back
                mem_we     = 1'b1;
                mem_wdata  = {nmin, {DATA_W{1'b0}}};
                ret_next   = nmin;
                p_next     = pnew;
                mem_raddr  = c1;
                state_next = internal ? ST_C1 : ST_POST;
            end
            ST_C1:
            begin
                mem_we     = 1'b1;
                mem_waddr  = c1;
                mem_wdata  = {rd_min, rd_pend + p_reg};
                mem_raddr  = c2;
                state_next = ST_C2;
            end
            ST_C2:
            begin
                mem_we     = 1'b1;
                mem_waddr  = c2;
                mem_wdata  = {rd_min, rd_pend + p_reg};
                state_next = ST_POST;
            end
            ST_POST:
            begin
                if (partial)
                begin
                    push       = 1'b1;
                    ph_we      = 1'b1;
                    ph_val     = PH_LEFT;
                    sp_next    = sp_reg + SPW'(1);
                    state_next = ST_VISIT;
                end
                else if (sp_reg == '0)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    sp_next    = sp_reg - SPW'(1);
                    state_next = ST_VISIT;
                end
            end
            ST_DONE:
            begin
                if (cmd_reg == CMD_MIN)
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_load   = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        // a fill write restarts the clearing pass
        if (cfg.refill)
        begin
            state_next = ST_CLR;
            clr_next   = '0;
        end
    end

`ifndef SYNTH
    a_clr_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLR) |-> in_stall)
        else $error("request accepted during clearing pass");

    a_result_query: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> (cmd_reg == CMD_MIN))
        else $error("result produced for a range add");

    a_stack_depth: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_CLR) |-> (sp_reg <= SPW'(D - 1)))
        else $error("frame stack overflow");
`endif

endmodule
`default_nettype wire
